[hdl/two_axis_position_complementary_filter_defines.svh]
// Assertion macros shared by the filter modules.
// Used through `include by the files that carry assertions; needs clk and rst in scope.
`ifndef TWO_AXIS_POSITION_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TWO_AXIS_POSITION_COMPLEMENTARY_FILTER_DEFINES_SVH
// Checked outside reset.
`define TAPCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define TAPCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/tapcf_pkg.sv]
// Package for the two-axis position complementary filter.
// Holds widths, register indexes, item types and the lane state type; no dependencies.
package tapcf_pkg;

  localparam int SW     = 32;  // sample width
  localparam int GW     = 24;  // gain width
  localparam int PW     = 24;  // period width
  localparam int CW     = 52;  // signed coefficient width, Q.40
  localparam int DW     = 51;  // denominator width
  localparam int MAW    = 27;  // multiplier operand A
  localparam int MBW    = 34;  // multiplier operand B
  localparam int PRW    = 61;  // product width
  localparam int AW     = 88;  // numerator accumulator width
  localparam int MW     = 89;  // rounded magnitude width
  localparam int CHUNK  = 26;  // coefficient split point
  localparam int NTERM  = 6;
  localparam int IDXW   = 3;
  localparam int CFGIW  = 3;

  localparam logic [4:0] COEF_LAST = 5'd4;
  localparam logic [4:0] MAC_LAST  = 5'd12;
  localparam logic [4:0] DIV_LAST  = 5'd31;

  localparam logic [CFGIW-1:0] REG_KI_SN  = 3'd0;
  localparam logic [CFGIW-1:0] REG_KP_SN  = 3'd1;
  localparam logic [CFGIW-1:0] REG_KI_EW  = 3'd2;
  localparam logic [CFGIW-1:0] REG_KP_EW  = 3'd3;
  localparam logic [CFGIW-1:0] REG_PERIOD = 3'd4;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    sample_t velocity_sn;
    sample_t velocity_ew;
    sample_t measured_sn;
    sample_t measured_ew;
  } in_t;

  typedef struct packed {
    sample_t estimate_sn;
    sample_t estimate_ew;
    logic    clipped;
  } out_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    sample_t estimate;
    logic    clipped;
  } lane_res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COEF, ST_MAC, ST_RND, ST_LOAD, ST_DIV, ST_FIN, ST_DONE
  } lane_state_t;

endpackage

[hdl/tapcf_lane.sv]
// One axis of the filter: coefficients, serial multiply-accumulate and restoring divide.
// Depends on tapcf_pkg and the assertion macro header.
`include "two_axis_position_complementary_filter_defines.svh"
module tapcf_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tapcf_pkg::GW-1:0]    ki,
  input  logic [tapcf_pkg::GW-1:0]    kp,
  input  logic [tapcf_pkg::PW-1:0]    period,
  input  logic                        start,
  input  tapcf_pkg::sample_t          velocity,
  input  tapcf_pkg::sample_t          measured,
  input  logic                        take,
  output tapcf_pkg::lane_res_t        res
);

  tapcf_pkg::lane_state_t state, state_next;
  logic [4:0] cnt;

  tapcf_pkg::sample_t vh0, vh1, xh0, xh1, yh0, yh1;
  logic signed [tapcf_pkg::MBW-1:0] smp  [tapcf_pkg::NTERM];
  logic signed [tapcf_pkg::CW-1:0]  coef [tapcf_pkg::NTERM];
  logic [tapcf_pkg::DW-1:0] den;
  logic [31:0] t2;
  logic [48:0] a_c;
  logic [49:0] b_c;
  logic signed [tapcf_pkg::PRW-1:0] prod;
  logic prod_hi;
  logic signed [tapcf_pkg::AW-1:0] acc;
  logic [tapcf_pkg::MW-1:0] magr;
  logic neg, ovf, clip;
  logic [tapcf_pkg::DW-1:0] rem;
  logic [31:0] qsh;
  tapcf_pkg::sample_t est;

  logic signed [tapcf_pkg::MAW-1:0] mul_a;
  logic signed [tapcf_pkg::MBW-1:0] mul_b;
  logic [tapcf_pkg::IDXW-1:0] idx;

  logic [48:0] t2_sum;
  logic [56:0] a_sum;
  logic signed [tapcf_pkg::CW-1:0] ae, be, four;
  logic signed [tapcf_pkg::AW-1:0] term;
  logic [tapcf_pkg::AW-1:0] mag;
  logic [tapcf_pkg::DW:0] r2, diff;
  logic ge;
  logic [31:0] lim, qv;
  logic sat;

  always_comb begin
    state_next = state;
    unique case (state)
      tapcf_pkg::ST_IDLE: if (start) state_next = tapcf_pkg::ST_COEF;
      tapcf_pkg::ST_COEF: if (cnt == tapcf_pkg::COEF_LAST) state_next = tapcf_pkg::ST_MAC;
      tapcf_pkg::ST_MAC:  if (cnt == tapcf_pkg::MAC_LAST) state_next = tapcf_pkg::ST_RND;
      tapcf_pkg::ST_RND:  state_next = tapcf_pkg::ST_LOAD;
      tapcf_pkg::ST_LOAD: state_next = tapcf_pkg::ST_DIV;
      tapcf_pkg::ST_DIV:  if (cnt == tapcf_pkg::DIV_LAST) state_next = tapcf_pkg::ST_FIN;
      tapcf_pkg::ST_FIN:  state_next = tapcf_pkg::ST_DONE;
      tapcf_pkg::ST_DONE: if (take) state_next = tapcf_pkg::ST_IDLE;
      default:            state_next = tapcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res.idle     = (state == tapcf_pkg::ST_IDLE);
    res.done     = (state == tapcf_pkg::ST_DONE);
    res.estimate = est;
    res.clipped  = clip;
    idx = (cnt[3:1] > 3'd5) ? 3'd0 : cnt[3:1];
    mul_a = $signed({3'b0, period});
    mul_b = $signed({10'b0, period});
    if (state == tapcf_pkg::ST_MAC) begin
      mul_a = cnt[0] ? $signed({coef[idx][tapcf_pkg::CW-1],
                                coef[idx][tapcf_pkg::CW-1:tapcf_pkg::CHUNK]})
                     : $signed({1'b0, coef[idx][tapcf_pkg::CHUNK-1:0]});
      mul_b = smp[idx];
    end else if (state == tapcf_pkg::ST_COEF) begin
      priority case (cnt)
        5'd1: mul_a = $signed({3'b0, kp});
        5'd2: begin
          mul_a = $signed({3'b0, ki});
          mul_b = $signed({2'b0, t2});
        end
        default: mul_a = $signed({3'b0, period});
      endcase
    end
  end

  always_comb begin
    t2_sum = {1'b0, prod[47:0]} + 49'd32768;
    a_sum  = {1'b0, prod[55:0]} + 57'd128;
    ae     = $signed({3'b0, a_c});
    be     = $signed({2'b0, b_c});
    four   = tapcf_pkg::CW'(64'sd4 <<< 40);
    term   = tapcf_pkg::AW'(prod);
    if (prod_hi) term = term <<< tapcf_pkg::CHUNK;
    mag    = acc[tapcf_pkg::AW-1] ? tapcf_pkg::AW'(-acc) : tapcf_pkg::AW'(acc);
    r2     = {rem, qsh[31]};
    diff   = r2 - {1'b0, den};
    ge     = (r2 >= {1'b0, den});
    lim    = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat    = ovf || (qsh > lim);
    qv     = sat ? lim : qsh;
  end

  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    prod_hi <= cnt[0];
    if (rst) begin
      state <= tapcf_pkg::ST_IDLE;
      cnt   <= '0;
      vh0 <= '0; vh1 <= '0; xh0 <= '0; xh1 <= '0; yh0 <= '0; yh1 <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 5'd0 : cnt + 5'd1;
      if (state == tapcf_pkg::ST_IDLE && start) begin
        vh1 <= vh0; vh0 <= velocity;
        xh1 <= xh0; xh0 <= measured;
      end
      if (state == tapcf_pkg::ST_FIN) begin
        yh1 <= yh0;
        yh0 <= neg ? -qv : qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tapcf_pkg::ST_IDLE: begin
        smp[0] <= tapcf_pkg::MBW'(velocity) - tapcf_pkg::MBW'(vh1);
        smp[1] <= tapcf_pkg::MBW'(measured);
        smp[2] <= tapcf_pkg::MBW'(xh0);
        smp[3] <= tapcf_pkg::MBW'(xh1);
        smp[4] <= tapcf_pkg::MBW'(yh0);
        smp[5] <= tapcf_pkg::MBW'(yh1);
        acc    <= '0;
      end
      tapcf_pkg::ST_COEF: begin
        priority case (cnt)
          5'd1: t2  <= t2_sum[47:16];
          5'd2: b_c <= {prod[48:0], 1'b0};
          5'd3: a_c <= a_sum[56:8];
          5'd4: begin
            coef[0] <= $signed({11'b0, period, 17'b0});
            coef[1] <= ae + be;
            coef[2] <= ae <<< 1;
            coef[3] <= ae - be;
            coef[4] <= (four <<< 1) - (ae <<< 1);
            coef[5] <= be - ae - four;
            den     <= {2'b0, a_c} + {1'b0, b_c} + tapcf_pkg::DW'(64'd1 << 42);
          end
          default: ;
        endcase
      end
      tapcf_pkg::ST_MAC: if (cnt != 5'd0) acc <= acc + term;
      tapcf_pkg::ST_RND: begin
        neg  <= acc[tapcf_pkg::AW-1];
        magr <= {1'b0, mag} + tapcf_pkg::MW'(den >> 1);
      end
      tapcf_pkg::ST_LOAD: begin
        ovf <= (magr[tapcf_pkg::MW-1:32] >= {6'b0, den});
        rem <= magr[82:32];
        qsh <= magr[31:0];
      end
      tapcf_pkg::ST_DIV: begin
        rem <= ge ? diff[tapcf_pkg::DW-1:0] : r2[tapcf_pkg::DW-1:0];
        qsh <= {qsh[30:0], ge};
      end
      tapcf_pkg::ST_FIN: begin
        est  <= neg ? -qv : qv;
        clip <= sat;
      end
      tapcf_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  `TAPCF_ASSERT(a_start_idle, start |-> state == tapcf_pkg::ST_IDLE, "start while lane busy")
  `TAPCF_ASSERT(a_div_len, (state == tapcf_pkg::ST_DIV && cnt == tapcf_pkg::DIV_LAST) |=> state == tapcf_pkg::ST_FIN, "divide did not end after last step")
  `TAPCF_ASSERT(a_fin_done, state == tapcf_pkg::ST_FIN |=> res.done, "result not posted after finish")
  `TAPCF_ASSERT_ALWAYS(a_rst_idle, $past(rst) |-> state == tapcf_pkg::ST_IDLE, "lane not idle after reset")

endmodule

[hdl/tapcf_merge.sv]
// Merging stage: joins both lane results into one output item and holds it in a register.
// Depends on tapcf_pkg and the assertion macro header.
`include "two_axis_position_complementary_filter_defines.svh"
module tapcf_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  tapcf_pkg::lane_res_t res_sn,
  input  tapcf_pkg::lane_res_t res_ew,
  input  logic                 out_ready,
  output logic                 take,
  output logic                 out_valid,
  output tapcf_pkg::out_t      out_data
);

  assign take = res_sn.done && res_ew.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (take) begin
      out_data.estimate_sn <= res_sn.estimate;
      out_data.estimate_ew <= res_ew.estimate;
      out_data.clipped     <= res_sn.clipped | res_ew.clipped;
    end
  end

  `TAPCF_ASSERT(a_take_valid, take |=> out_valid, "merged item not presented")
  `TAPCF_ASSERT(a_rise_take, $rose(out_valid) |-> $past(take), "output valid without merge")
  `TAPCF_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid, "output valid after reset")

endmodule

[hdl/two_axis_position_complementary_filter.sv]
// Two-axis position complementary filter: one item in gives one estimate item out. Each axis
// lane works its coefficients, then its numerator through its one 27x34 multiplier, then runs
// a restoring divider, with states for rounding, divider load, finish, hand-off and idle.
// A new item is taken only while both lanes are idle.
// A finished item waits in the output register while the next one is worked.
module two_axis_position_complementary_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tapcf_pkg::CFGIW-1:0]   wr_index,
  input  logic [tapcf_pkg::GW-1:0]      wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tapcf_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tapcf_pkg::out_t               out_data
);

  logic [tapcf_pkg::GW-1:0] ki_sn, kp_sn, ki_ew, kp_ew;
  logic [tapcf_pkg::PW-1:0] period;
  tapcf_pkg::lane_res_t res_sn, res_ew;
  logic take, start;

  always_ff @(posedge clk) begin
    if (rst) begin
      ki_sn  <= '0;
      kp_sn  <= 24'd65536;
      ki_ew  <= '0;
      kp_ew  <= 24'd65536;
      period <= 24'd83886;
    end else if (wr_en) begin
      case (wr_index)
        tapcf_pkg::REG_KI_SN:  ki_sn  <= wr_data;
        tapcf_pkg::REG_KP_SN:  kp_sn  <= wr_data;
        tapcf_pkg::REG_KI_EW:  ki_ew  <= wr_data;
        tapcf_pkg::REG_KP_EW:  kp_ew  <= wr_data;
        tapcf_pkg::REG_PERIOD: period <= wr_data;
        default: ;
      endcase
    end
  end

  assign in_ready = res_sn.idle && res_ew.idle;
  assign start    = in_valid && in_ready;

  tapcf_lane u_lane_sn (
    .clk(clk), .rst(rst), .ki(ki_sn), .kp(kp_sn), .period(period), .start(start),
    .velocity(in_data.velocity_sn), .measured(in_data.measured_sn), .take(take),
    .res(res_sn)
  );

  tapcf_lane u_lane_ew (
    .clk(clk), .rst(rst), .ki(ki_ew), .kp(kp_ew), .period(period), .start(start),
    .velocity(in_data.velocity_ew), .measured(in_data.measured_ew), .take(take),
    .res(res_ew)
  );

  tapcf_merge u_merge (
    .clk(clk), .rst(rst), .res_sn(res_sn), .res_ew(res_ew), .out_ready(out_ready),
    .take(take), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
